### hdl/lgre_pkg.sv
// ----------------------------------------------------------------------------
// Life row engine package
// Shared widths, types and helpers for the B3/S23 row engine.
// ----------------------------------------------------------------------------
package lgre_pkg;

   localparam int COLUMNS        = 64;
   localparam int ROW_WIDTH_BITS = 7;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(COLUMNS);

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef logic [COLUMNS-1:0] row_type;

   // 3x3 neighbourhood of one cell, bit 1 of each triple is the cell's own column
   typedef struct packed {
      logic [2:0] above;
      logic [2:0] here;
      logic [2:0] below;
   } neighbourhood_type;

   typedef struct packed {
      row_type cells;
      logic    frame_end;
      logic    run_end;
   } result_type;

   function automatic row_type live_mask(input logic [ROW_WIDTH_BITS-1:0] width);
      row_type mask;
      mask = '0;
      for (int k = 0; k < COLUMNS; k++) begin
         mask[k] = (width > ROW_WIDTH_BITS'(k));
      end
      return mask;
   endfunction

endpackage

### hdl/lgre_cell_lane.sv
// ----------------------------------------------------------------------------
// Life cell lane
// Applies the born-on-3, survives-on-2-or-3 rule to one cell.
// ----------------------------------------------------------------------------
module lgre_cell_lane
   import lgre_pkg::*;
(
   input  neighbourhood_type nbh,
   output logic              alive
);

   logic [3:0] count;

   assign count = 4'(nbh.above[0]) + 4'(nbh.above[1]) + 4'(nbh.above[2])
                + 4'(nbh.here[0])                     + 4'(nbh.here[2])
                + 4'(nbh.below[0]) + 4'(nbh.below[1]) + 4'(nbh.below[2]);

   assign alive = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && nbh.here[1]);

endmodule

### hdl/lgre_row_compute.sv
// ----------------------------------------------------------------------------
// Life row compute
// One lane per column; the merge stage gathers the lanes and masks dead columns.
// ----------------------------------------------------------------------------
module lgre_row_compute
   import lgre_pkg::*;
(
   input  row_type above,
   input  row_type here,
   input  row_type below,
   input  row_type mask,
   output row_type next_row
);

   logic [COLUMNS+1:0] above_pad;
   logic [COLUMNS+1:0] here_pad;
   logic [COLUMNS+1:0] below_pad;
   row_type            lane_alive;

   // columns outside the grid are dead
   assign above_pad = {1'b0, above, 1'b0};
   assign here_pad  = {1'b0, here,  1'b0};
   assign below_pad = {1'b0, below, 1'b0};

   for (genvar k = 0; k < COLUMNS; k++) begin : g_lane
      neighbourhood_type nbh;
      assign nbh.above = above_pad[k+2:k];
      assign nbh.here  = here_pad[k+2:k];
      assign nbh.below = below_pad[k+2:k];

      lgre_cell_lane u_lane (
         .nbh   (nbh),
         .alive (lane_alive[k])
      );
   end

   assign next_row = lane_alive & mask;

endmodule

### hdl/lgre_result_queue.sv
// ----------------------------------------------------------------------------
// Life result queue
// Small result buffer taking up to two rows per cycle and giving one.
// ----------------------------------------------------------------------------
module lgre_result_queue
   import lgre_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                push_count,
   input  result_type                push_first,
   input  result_type                push_second,
   input  logic                      pop,
   output result_type                head,
   output logic [QUEUE_CNT_BITS-1:0] fill
);

   result_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_BITS'(1);
   assign wr_ptr_in   = wr_ptr_ff + QUEUE_PTR_BITS'(push_count);
   assign rd_ptr_in   = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
   assign count_in    = count_ff + QUEUE_CNT_BITS'(push_count) - QUEUE_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_second;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign fill = count_ff;

endmodule

### hdl/life_generation_row_engine_unit.sv
// ----------------------------------------------------------------------------
// Life generation row engine
// Computes one B3/S23 generation of a grid, one row per transaction.
// ----------------------------------------------------------------------------
// Rows enter on req_* (tdata = row cells, tlast = bottom row of the grid) and
// next-generation rows leave on rsp_* (tlast = last row caused by that input,
// tuser = bottom row of the new generation). A row's result appears once the
// row below it arrives; the bottom row gives two results, a one-row grid one.
// csr_wr_en/csr_wr_data set the row width (1..64, reset 64); write it only
// while the block is idle.
// Results are registered in the result queue before they appear on rsp_*.
// Rows are taken at one per cycle while req_tready is high; a bottom row with a
// row above yields two results and so occupies the output for two transfers.
// Parallel lanes compute all 64 cells at once from the held rows and req_tdata.
// A four-entry result queue decouples the sides: req_tready stays high while
// at least two entries are free, so a stalled receiver backs up into the
// queue and then holds off input. Reset empties the queue, forgets held rows
// and sets the width to 64.
// ----------------------------------------------------------------------------
module life_generation_row_engine_unit
   import lgre_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ROW_WIDTH_BITS-1:0] csr_wr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // [63:0] row_cells
   input  logic                      req_tlast,   // frame_last_row
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [63:0]               rsp_tdata,   // [63:0] next_row_cells
   output logic                      rsp_tlast,   // run_end
   output logic                      rsp_tuser    // frame_end
);

   logic [ROW_WIDTH_BITS-1:0] width_ff, width_in;
   row_type                   upper_ff, upper_in;
   row_type                   middle_ff, middle_in;
   logic                      held_ff, held_in;

   row_type                   mask;
   row_type                   row_in;
   row_type                   mid_row_next;
   row_type                   last_row_next;
   row_type                   last_above;
   logic                      req_fire;
   logic                      rsp_fire;
   logic [1:0]                push_count;
   result_type                mid_result;
   result_type                last_result;
   result_type                push_first;
   result_type                head;
   logic [QUEUE_CNT_BITS-1:0] fill;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   assign mask       = live_mask(width_ff);
   assign row_in     = req_tdata & mask;
   assign last_above = held_ff ? middle_ff : '0;

   lgre_row_compute u_mid_row (
      .above    (upper_ff),
      .here     (middle_ff),
      .below    (row_in),
      .mask     (mask),
      .next_row (mid_row_next)
   );

   lgre_row_compute u_last_row (
      .above    (last_above),
      .here     (row_in),
      .below    ('0),
      .mask     (mask),
      .next_row (last_row_next)
   );

   assign mid_result  = '{cells: mid_row_next, frame_end: 1'b0, run_end: !req_tlast};
   assign last_result = '{cells: last_row_next, frame_end: 1'b1, run_end: 1'b1};
   assign push_first  = held_ff ? mid_result : last_result;
   assign push_count  = req_fire ? (2'(held_ff) + 2'(req_tlast)) : 2'd0;

   always_comb begin
      width_in  = width_ff;
      upper_in  = upper_ff;
      middle_in = middle_ff;
      held_in   = held_ff;
      if (csr_wr_en) begin
         width_in = csr_wr_data;
      end
      if (req_fire) begin
         if (req_tlast) begin
            upper_in  = '0;
            middle_in = '0;
            held_in   = 1'b0;
         end else begin
            upper_in  = last_above;
            middle_in = row_in;
            held_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ROW_WIDTH_RESET;
         upper_ff  <= '0;
         middle_ff <= '0;
         held_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
         held_ff   <= held_in;
      end
   end

   lgre_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (last_result),
      .pop         (rsp_fire),
      .head        (head),
      .fill        (fill)
   );

   assign req_tready = (fill <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign rsp_tvalid = (fill != '0);
   assign rsp_tdata  = head.cells;
   assign rsp_tlast  = head.run_end;
   assign rsp_tuser  = head.frame_end;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_first_row_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && !held_ff && !req_tlast |=> fill <= $past(fill))
      else $error("first row of a frame produced a result");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> !held_ff && (upper_ff == '0) && (middle_ff == '0))
      else $error("held rows not cleared at end of frame");

   a_frame_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("bottom row result not marked as last of its run");

endmodule
